// ----- sv/hfpc_pkg.sv -----
// ----------------------------------------------------------------------------
// hfpc_pkg
// Shared types, constants and plane math for the frustum polygon clipper.
// ----------------------------------------------------------------------------
package hfpc_pkg;

   localparam int MaxInVerts    = 8;
   localparam int MaxStoreVerts = 16;
   localparam int ResultLimit   = 16;
   localparam int MinVerts      = 3;
   localparam int NumPlanes     = 6;

   localparam int PvW  = 34;   // plane value w +/- axis
   localparam int DenW = 35;   // difference of two plane values
   localparam int TW   = 31;   // Q1.30 interpolation factor

   // index 0..3 = x, y, z, w
   typedef logic [3:0][31:0] vert_type;

   function automatic logic signed [PvW-1:0] plane_val(input vert_type v,
                                                       input logic [2:0] plane);
      logic signed [PvW-1:0] wv;
      logic signed [PvW-1:0] av;
      wv = PvW'(signed'(v[3]));
      av = PvW'(signed'(v[plane[2:1]]));
      plane_val = plane[0] ? (wv - av) : (wv + av);
   endfunction

endpackage

// ----- sv/hfpc_vstore.sv -----
// ----------------------------------------------------------------------------
// hfpc_vstore
// Ping-pong vertex store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hfpc_vstore #(
   parameter int DEPTH = 2 * hfpc_pkg::MaxStoreVerts,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  hfpc_pkg::vert_type wr_data,
   input  logic [AW-1:0]      rd_addr,
   output hfpc_pkg::vert_type rd_data
);

   hfpc_pkg::vert_type mem [DEPTH];
   hfpc_pkg::vert_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/hfpc_div.sv -----
// ----------------------------------------------------------------------------
// hfpc_div
// Restoring divider, one quotient bit per cycle:
// t = floor((an * 2^30 + dn / 2) / dn), quotient known to be below 2^31.
// ----------------------------------------------------------------------------
module hfpc_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [hfpc_pkg::PvW-1:0]     an,
   input  logic [hfpc_pkg::DenW-1:0]    dn,
   output logic                         done,
   output logic [hfpc_pkg::TW-1:0]      quot
);

   localparam int DW = hfpc_pkg::DenW;
   localparam int TW = hfpc_pkg::TW;

   logic          run_ff,  run_in;
   logic          done_ff, done_in;
   logic [4:0]    cnt_ff,  cnt_in;
   logic [DW-1:0] rem_ff,  rem_in;
   logic [DW-1:0] dn_ff,   dn_in;
   logic [TW-1:0] low_ff,  low_in;
   logic [TW-1:0] q_ff,    q_in;

   logic [63:0]   num;
   logic [DW:0]   trial;
   logic          ge;

   always_comb begin
      num     = {an[33:0], 30'd0} + 64'(dn >> 1);
      trial   = {rem_ff, low_ff[TW-1]};
      ge      = trial >= {1'b0, dn_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dn_in   = dn_ff;
      low_in  = low_ff;
      q_in    = q_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = 5'(TW - 1);
         rem_in = DW'(num[63:TW]);
         low_in = num[TW-1:0];
         dn_in  = dn;
      end else if (run_ff) begin
         rem_in = ge ? DW'(trial - {1'b0, dn_ff}) : DW'(trial);
         q_in   = {q_ff[TW-2:0], ge};
         low_in = {low_ff[TW-2:0], 1'b0};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dn_ff  <= dn_in;
      low_ff <= low_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

// ----- sv/homogeneous_frustum_polygon_clipper.sv -----
// ----------------------------------------------------------------------------
// homogeneous_frustum_polygon_clipper
// Sutherland-Hodgman clipper of one clip-space polygon against the six
// frustum planes, Q16.16 vertices, ping-pong vertex store.
// ----------------------------------------------------------------------------
// Usage:
//  Input: one vertex word per start pulse while busy is low; req_poly_end
//  marks the last vertex. A vertex word without req_poly_end gives no
//  result. Vertices beyond the input capacity are dropped and reported
//  in rsp_overflowed.
//  On the last vertex the block goes busy and runs up to six passes over
//  the store. Each edge crossing goes through the 31-step bit-serial
//  divider, four multiply/add pairs and one store write.
//  Output: after a read-priming step, results leave one per cycle on
//  rsp_strobe, rsp_run_last on the final one; a clipped-away polygon gives
//  one word with rsp_poly_empty the cycle after its pass ends.
//  Results cannot be stalled. busy falls with the last strobe.
//  Reset: synchronous; vertex count and drop flag clear, store contents
//  need no clearing.
// ----------------------------------------------------------------------------
module homogeneous_frustum_polygon_clipper #(
   parameter int MAX_IN_VERTS    = hfpc_pkg::MaxInVerts,
   parameter int MAX_STORE_VERTS = hfpc_pkg::MaxStoreVerts
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_vert_x,
   input  logic [31:0] req_vert_y,
   input  logic [31:0] req_vert_z,
   input  logic [31:0] req_vert_w,
   input  logic        req_poly_end,
   output logic        rsp_strobe,
   output logic [31:0] rsp_out_x,
   output logic [31:0] rsp_out_y,
   output logic [31:0] rsp_out_z,
   output logic [31:0] rsp_out_w,
   output logic        rsp_poly_empty,
   output logic        rsp_overflowed,
   output logic        rsp_run_last
);

   localparam int Cap   = (MAX_IN_VERTS < MAX_STORE_VERTS) ? MAX_IN_VERTS : MAX_STORE_VERTS;
   localparam int CW    = $clog2(Cap + 1);
   localparam int NW    = $clog2(MAX_STORE_VERTS + 1);
   localparam int Depth = 2 * MAX_STORE_VERTS;
   localparam int AW    = $clog2(Depth);
   localparam int PvW   = hfpc_pkg::PvW;
   localparam int DenW  = hfpc_pkg::DenW;
   localparam int TW    = hfpc_pkg::TW;

   typedef enum logic [11:0] {
      S_IDLE   = 12'b0000_0000_0001,
      S_RDPREV = 12'b0000_0000_0010,
      S_LDPREV = 12'b0000_0000_0100,
      S_CURR   = 12'b0000_0000_1000,
      S_EVAL   = 12'b0000_0001_0000,
      S_DIV    = 12'b0000_0010_0000,
      S_MUL    = 12'b0000_0100_0000,
      S_MADD   = 12'b0000_1000_0000,
      S_WHIT   = 12'b0001_0000_0000,
      S_WCUR   = 12'b0010_0000_0000,
      S_NEXT   = 12'b0100_0000_0000,
      S_OUT    = 12'b1000_0000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      vcount_ff, vcount_in;
   logic               drop_ff, drop_in;
   logic [NW-1:0]      n_ff, n_in;
   logic [NW-1:0]      m_ff, m_in;
   logic [NW-1:0]      i_ff, i_in;
   logic [NW-1:0]      k_ff, k_in;
   logic               src_ff, src_in;
   logic [2:0]         plane_ff, plane_in;
   logic [1:0]         c_ff, c_in;
   logic               cin_ff, cin_in;
   logic               emit_ff, emit_in;
   hfpc_pkg::vert_type prev_ff, prev_in;
   hfpc_pkg::vert_type curr_ff, curr_in;
   hfpc_pkg::vert_type hit_ff, hit_in;
   logic [63:0]        prod_ff, prod_in;
   logic               strobe_ff, strobe_in;
   hfpc_pkg::vert_type rv_ff, rv_in;
   logic               empty_ff, empty_in;
   logic               ovf_ff, ovf_in;
   logic               last_ff, last_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   hfpc_pkg::vert_type wr_data;
   logic [AW-1:0]      rd_addr;
   hfpc_pkg::vert_type rd_data;

   logic               div_start;
   logic [PvW-1:0]     div_an;
   logic [DenW-1:0]    div_dn;
   logic               div_done;
   logic [TW-1:0]      div_q;

   logic signed [PvW-1:0]  pa, pb;
   logic signed [DenW-1:0] den;
   logic                   pin, cin;
   logic signed [32:0]     dcoord;
   logic [32:0]            dmag;
   logic [TW-1:0]          tq;
   logic [32:0]            qr;
   logic [33:0]            res;

   function automatic logic [AW-1:0] slot(input logic bank, input logic [NW-1:0] idx);
      slot = bank ? AW'(MAX_STORE_VERTS) + AW'(idx) : AW'(idx);
   endfunction

   hfpc_vstore #(.DEPTH(Depth), .AW(AW)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   hfpc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .an    (div_an),
      .dn    (div_dn),
      .done  (div_done),
      .quot  (div_q)
   );

   always_comb begin
      pa     = hfpc_pkg::plane_val(prev_ff, plane_ff);
      pb     = hfpc_pkg::plane_val(curr_ff, plane_ff);
      pin    = !pa[PvW-1];
      cin    = !pb[PvW-1];
      den    = DenW'(pa) - DenW'(pb);
      div_an = pa[PvW-1] ? PvW'(-pa) : PvW'(pa);
      div_dn = den[DenW-1] ? DenW'(-den) : DenW'(den);
      dcoord = 33'(signed'(curr_ff[c_ff])) - 33'(signed'(prev_ff[c_ff]));
      dmag   = dcoord[32] ? 33'(-dcoord) : 33'(dcoord);
      tq     = (div_q > TW'(1 << 30)) ? TW'(1 << 30) : div_q;
      qr     = prod_ff[62:30] + 33'(prod_ff[29]);
      res    = dcoord[32] ? (34'(signed'(prev_ff[c_ff])) - 34'(qr))
                          : (34'(signed'(prev_ff[c_ff])) + 34'(qr));
   end

   always_comb begin
      state_in  = state_ff;
      vcount_in = vcount_ff;
      drop_in   = drop_ff;
      n_in      = n_ff;
      m_in      = m_ff;
      i_in      = i_ff;
      k_in      = k_ff;
      src_in    = src_ff;
      plane_in  = plane_ff;
      c_in      = c_ff;
      cin_in    = cin_ff;
      emit_in   = 1'b0;
      prev_in   = prev_ff;
      curr_in   = curr_ff;
      hit_in    = hit_ff;
      prod_in   = prod_ff;
      strobe_in = 1'b0;
      rv_in     = rv_ff;
      empty_in  = empty_ff;
      ovf_in    = ovf_ff;
      last_in   = last_ff;
      wr_en     = 1'b0;
      wr_addr   = slot(!src_ff, m_ff);
      wr_data   = curr_ff;
      rd_addr   = slot(src_ff, i_ff);
      div_start = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               wr_addr = slot(1'b0, NW'(vcount_ff));
               wr_data = {req_vert_w, req_vert_z, req_vert_y, req_vert_x};
               if (vcount_ff < CW'(Cap)) begin
                  wr_en     = 1'b1;
                  vcount_in = vcount_ff + CW'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_poly_end) begin
                  n_in     = NW'(vcount_in);
                  src_in   = 1'b0;
                  plane_in = 3'd0;
                  m_in     = '0;
                  i_in     = '0;
                  state_in = S_RDPREV;
               end
            end
         end
         S_RDPREV: begin
            rd_addr = slot(src_ff, n_ff - NW'(1));
            if (n_ff == '0) begin
               strobe_in = 1'b1;
               rv_in     = '0;
               empty_in  = 1'b1;
               ovf_in    = drop_ff;
               last_in   = 1'b1;
               vcount_in = '0;
               drop_in   = 1'b0;
               state_in  = S_IDLE;
            end else begin
               state_in = S_LDPREV;
            end
         end
         S_LDPREV: begin
            prev_in  = rd_data;
            rd_addr  = slot(src_ff, '0);
            state_in = S_CURR;
         end
         S_CURR: begin
            curr_in  = rd_data;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            cin_in = cin;
            if (cin != pin) begin
               if (den == '0) begin
                  hit_in   = prev_ff;
                  state_in = S_WHIT;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end else if (cin) begin
               state_in = S_WCUR;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_DIV: begin
            c_in = 2'd0;
            if (div_done) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = 64'(dmag) * 64'(tq);
            state_in = S_MADD;
         end
         S_MADD: begin
            hit_in[c_ff] = res[31:0];
            c_in         = c_ff + 2'd1;
            state_in     = (c_ff == 2'd3) ? S_WHIT : S_MUL;
         end
         S_WHIT: begin
            wr_data = hit_ff;
            if (m_ff < NW'(MAX_STORE_VERTS)) begin
               wr_en = 1'b1;
               m_in  = m_ff + NW'(1);
            end else begin
               drop_in = 1'b1;
            end
            state_in = cin_ff ? S_WCUR : S_NEXT;
         end
         S_WCUR: begin
            wr_data = curr_ff;
            if (m_ff < NW'(MAX_STORE_VERTS)) begin
               wr_en = 1'b1;
               m_in  = m_ff + NW'(1);
            end else begin
               drop_in = 1'b1;
            end
            state_in = S_NEXT;
         end
         S_NEXT: begin
            prev_in = curr_ff;
            if (i_ff + NW'(1) == n_ff) begin
               n_in     = m_ff;
               m_in     = '0;
               i_in     = '0;
               src_in   = !src_ff;
               plane_in = plane_ff + 3'd1;
               rd_addr  = slot(!src_ff, '0);
               if (m_ff < NW'(hfpc_pkg::MinVerts)) begin
                  strobe_in = 1'b1;
                  rv_in     = '0;
                  empty_in  = 1'b1;
                  ovf_in    = drop_ff;
                  last_in   = 1'b1;
                  vcount_in = '0;
                  drop_in   = 1'b0;
                  state_in  = S_IDLE;
               end else if (plane_ff == 3'(hfpc_pkg::NumPlanes - 1)) begin
                  if (32'(m_ff) > 32'(hfpc_pkg::ResultLimit)) begin
                     k_in    = NW'(hfpc_pkg::ResultLimit);
                     drop_in = 1'b1;
                  end else begin
                     k_in = m_ff;
                  end
                  state_in = S_OUT;
               end else begin
                  state_in = S_RDPREV;
               end
            end else begin
               i_in     = i_ff + NW'(1);
               rd_addr  = slot(src_ff, i_ff + NW'(1));
               state_in = S_CURR;
            end
         end
         S_OUT: begin
            // first cycle only primes the read
            emit_in = 1'b1;
            rd_addr = slot(src_ff, i_ff);
            if (emit_ff) begin
               strobe_in = 1'b1;
               rv_in     = rd_data;
               empty_in  = 1'b0;
               ovf_in    = drop_ff;
               last_in   = (i_ff + NW'(1) == k_ff);
               i_in      = i_ff + NW'(1);
               rd_addr   = slot(src_ff, i_ff + NW'(1));
               if (i_ff + NW'(1) == k_ff) begin
                  vcount_in = '0;
                  drop_in   = 1'b0;
                  state_in  = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // S_OUT read pipeline: index i_ff holds the word being read
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         vcount_ff <= '0;
         drop_ff   <= 1'b0;
         strobe_ff <= 1'b0;
         emit_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         vcount_ff <= vcount_in;
         drop_ff   <= drop_in;
         strobe_ff <= strobe_in;
         emit_ff   <= emit_in;
      end
      n_ff     <= n_in;
      m_ff     <= m_in;
      i_ff     <= (state_ff == S_OUT && !emit_ff) ? i_ff : i_in;
      k_ff     <= k_in;
      src_ff   <= src_in;
      plane_ff <= plane_in;
      c_ff     <= c_in;
      cin_ff   <= cin_in;
      prev_ff  <= prev_in;
      curr_ff  <= curr_in;
      hit_ff   <= hit_in;
      prod_ff  <= prod_in;
      rv_ff    <= rv_in;
      empty_ff <= empty_in;
      ovf_ff   <= ovf_in;
      last_ff  <= last_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_strobe     = strobe_ff;
   assign rsp_out_x      = rv_ff[0];
   assign rsp_out_y      = rv_ff[1];
   assign rsp_out_z      = rv_ff[2];
   assign rsp_out_w      = rv_ff[3];
   assign rsp_poly_empty = empty_ff;
   assign rsp_overflowed = ovf_ff;
   assign rsp_run_last   = last_ff;

endmodule

// ----- verif/homogeneous_frustum_polygon_clipper_tb.sv -----
// ----------------------------------------------------------------------------
// homogeneous_frustum_polygon_clipper_tb
// Drives random and directed clip-space polygons one vertex word at a time,
// predicts the clipped vertices with an independent Sutherland-Hodgman
// model in Q16.16, and compares every result word against it.
// ----------------------------------------------------------------------------
module homogeneous_frustum_polygon_clipper_tb;

   typedef struct packed {
      logic [31:0] x, y, z, w;
      logic        last_vert;
   } vert_word_type;

   typedef struct packed {
      logic [31:0] x, y, z, w;
      logic        empty, ovf, last;
   } clip_word_type;

   typedef longint vtx_type [4];

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_vert_x = '0, req_vert_y = '0, req_vert_z = '0, req_vert_w = '0;
   logic        req_poly_end = 1'b0;
   logic        rsp_strobe;
   logic [31:0] rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w;
   logic        rsp_poly_empty, rsp_overflowed, rsp_run_last;

   vert_word_type pending_verts[$];
   clip_word_type expected_clip[$];
   int            errors = 0;
   int            gap_left = 0;
   bit            quiet_tail = 0;
   int            idle_cycles = 0;
   bit            accepted_at_edge = 0;

   // predictor state
   vtx_type in_poly[$];
   bit      drop_seen = 0;

   always #2 clock = ~clock;

   homogeneous_frustum_polygon_clipper u_dut (.*);

   function automatic longint pl_value(vtx_type v, int p);
      return (p % 2) ? v[3] - v[p/2] : v[3] + v[p/2];
   endfunction

   function automatic longint mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic vtx_type edge_hit(vtx_type a, vtx_type b, int p);
      longint av, bv, dn;
      longint unsigned an, dm, t, q;
      vtx_type r;
      av = pl_value(a, p);
      bv = pl_value(b, p);
      dn = av - bv;
      if (dn == 0) return a;
      an = mag(av);
      dm = mag(dn);
      t = ((an << 30) + dm / 2) / dm;
      if (t > (64'd1 << 30)) t = 64'd1 << 30;
      for (int i = 0; i < 4; i++) begin
         q = (longint'(mag(b[i] - a[i])) * t + (64'd1 << 29)) >> 30;
         r[i] = (b[i] < a[i]) ? a[i] - longint'(q) : a[i] + longint'(q);
      end
      return r;
   endfunction

   task automatic push_clip(ref vtx_type dst[$], input vtx_type v);
      if (dst.size() < hfpc_pkg::MaxStoreVerts) dst.insert(dst.size(), v);
      else drop_seen = 1;
   endtask

   task automatic predict_clip(input vert_word_type vw);
      vtx_type src[$];
      vtx_type dst[$];
      vtx_type v, prev;
      bit      pin, cin;
      int      k;
      clip_word_type cw;
      if (in_poly.size() < hfpc_pkg::MaxInVerts) begin
         v[0] = longint'(signed'(vw.x));
         v[1] = longint'(signed'(vw.y));
         v[2] = longint'(signed'(vw.z));
         v[3] = longint'(signed'(vw.w));
         in_poly.insert(in_poly.size(), v);
      end else drop_seen = 1;
      if (!vw.last_vert) return;
      src = in_poly;
      for (int p = 0; p < hfpc_pkg::NumPlanes; p++) begin
         dst.delete();
         if (src.size() > 0) begin
            prev = src[src.size()-1];
            pin = pl_value(prev, p) >= 0;
            foreach (src[i]) begin
               cin = pl_value(src[i], p) >= 0;
               if (cin) begin
                  if (!pin) push_clip(dst, edge_hit(prev, src[i], p));
                  push_clip(dst, src[i]);
               end else if (pin) push_clip(dst, edge_hit(prev, src[i], p));
               prev = src[i];
               pin = cin;
            end
         end
         src = dst;
         if (src.size() < hfpc_pkg::MinVerts) break;
      end
      if (src.size() < hfpc_pkg::MinVerts) begin
         cw = '{x: 0, y: 0, z: 0, w: 0, empty: 1, ovf: drop_seen, last: 1};
         expected_clip.insert(expected_clip.size(), cw);
      end else begin
         k = src.size();
         if (k > hfpc_pkg::ResultLimit) begin
            k = hfpc_pkg::ResultLimit;
            drop_seen = 1;
         end
         for (int i = 0; i < k; i++) begin
            cw.x = src[i][0][31:0];
            cw.y = src[i][1][31:0];
            cw.z = src[i][2][31:0];
            cw.w = src[i][3][31:0];
            cw.empty = 0;
            cw.ovf = drop_seen;
            cw.last = (i == k - 1);
            expected_clip.insert(expected_clip.size(), cw);
         end
      end
      in_poly.delete();
      drop_seen = 0;
   endtask

   always @(posedge clock) begin
      accepted_at_edge <= !reset && start && !busy;
      if (!reset && start && !busy) predict_clip(pending_verts.pop_front());
   end

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (start && !accepted_at_edge) begin
            // still waiting on busy
         end else if (gap_left > 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_verts.size() > 0) begin
            if (!quiet_tail && $urandom_range(0, 5) == 0) begin
               start <= 1'b0;
               gap_left <= $urandom_range(1, 11) - 1;
            end else begin
               start <= 1'b1;
               req_vert_x <= pending_verts[0].x;
               req_vert_y <= pending_verts[0].y;
               req_vert_z <= pending_verts[0].z;
               req_vert_w <= pending_verts[0].w;
               req_poly_end <= pending_verts[0].last_vert;
            end
         end else start <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      clip_word_type exp_w;
      if (!reset && rsp_strobe) begin
         if (expected_clip.size() == 0) begin
            $display("%0t: unexpected result x=%h y=%h z=%h w=%h", $time,
                     rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w);
            errors++;
         end else begin
            exp_w = expected_clip.pop_front();
            if ({rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w, rsp_poly_empty,
                 rsp_overflowed, rsp_run_last} !== exp_w) begin
               $display("%0t: mismatch expected %h %h %h %h e%b o%b l%b", $time,
                        exp_w.x, exp_w.y, exp_w.z, exp_w.w, exp_w.empty, exp_w.ovf,
                        exp_w.last);
               $display("%0t:          actual   %h %h %h %h e%b o%b l%b", $time,
                        rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w, rsp_poly_empty,
                        rsp_overflowed, rsp_run_last);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("homogeneous_frustum_polygon_clipper_tb: FAIL");
         $finish;
      end
   end

   function automatic logic [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom();
         1: return 32'(signed'($urandom_range(0, 8 << 16)) - (4 << 16));
         default: return 32'(signed'($urandom_range(0, 3 << 16)) - (3 << 15));
      endcase
   endfunction

   task automatic add_vert(logic [31:0] x, y, z, w, logic e);
      vert_word_type v;
      v = '{x: x, y: y, z: z, w: w, last_vert: e};
      pending_verts.insert(pending_verts.size(), v);
   endtask

   task automatic add_poly(int n, int mode);
      for (int i = 0; i < n; i++)
         add_vert(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                  32'($urandom_range(1 << 15, 3 << 16)) | (mode == 0 ? $urandom() : 0),
                  i == n - 1);
   endtask

   initial begin
      int total;
      // directed: fully inside triangle
      add_vert(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 0);
      add_vert(32'h0000_8000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 0);
      add_vert(32'h0000_0000, 32'h0000_8000, 32'h0000_0000, 32'h0001_0000, 1);
      // single vertex polygon, clipped away
      add_vert(32'h0, 32'h0, 32'h0, 32'h0001_0000, 1);
      // triangle crossing every plane, extreme values
      add_vert(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
      add_vert(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
      add_vert(32'h0, 32'h0, 32'h0, 32'h8000_0000, 1);
      // more than the input capacity: ten vertices of a big square
      for (int i = 0; i < 10; i++)
         add_vert((i % 4 < 2) ? 32'hFFFD_0000 : 32'h0003_0000,
                  (i % 4 == 1 || i % 4 == 2) ? 32'h0003_0000 : 32'hFFFD_0000,
                  (i % 2) ? 32'h0002_0000 : 32'hFFFE_0000, 32'h0001_0000, i == 9);
      // zero denominator edge, vertices on the plane
      add_vert(32'hFFFF_0000, 32'h0, 32'h0, 32'h0001_0000, 0);
      add_vert(32'hFFFF_0000, 32'h0001_0000, 32'h0, 32'h0001_0000, 0);
      add_vert(32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 1);
      total = pending_verts.size();
      while (total < 120) begin
         int n;
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 12) : $urandom_range(3, 8);
         add_poly(n, $urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 2));
         total += n;
      end
      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      while (pending_verts.size() > 20) @(posedge clock);
      quiet_tail = 1;
      while (pending_verts.size() > 0 || expected_clip.size() > 0 || busy)
         @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) $display("homogeneous_frustum_polygon_clipper_tb: PASS");
      else $display("homogeneous_frustum_polygon_clipper_tb: FAIL");
      $finish;
   end
endmodule
